// ----- hw/rtl/periodic_can_message_scheduler_top_defines.svh -----
// Assertion macros shared by the periodic CAN message scheduler RTL.
`ifndef PERIODIC_CAN_MESSAGE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_CAN_MESSAGE_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pcms_pkg.sv -----
// Package with types, codes and helpers of the periodic CAN message scheduler.
`timescale 1ns / 1ps
package pcms_pkg;

    // Default number of message slots.
    localparam int NUM_SLOTS_DEF = 4;

    // Largest valid data length code.
    localparam logic [7:0] MAX_DLC = 8'd8;

    // Request type codes.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_CFG  = 2'd1;
    localparam logic [1:0] REQ_SEND = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CFG,
        ST_SCAN,
        ST_FLUSH,
        ST_SEND
    } state_t;

    // One CAN message as stored and emitted.
    typedef struct packed {
        logic [31:0] id;
        logic [3:0]  len;
        logic [63:0] data;
    } msg_t;

    // Mask that covers the first len payload bytes.
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < len)
            begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/periodic_can_message_scheduler_top.sv -----
// Top level of the periodic CAN message scheduler: slot table and its sequencer.
`timescale 1ns / 1ps
`include "periodic_can_message_scheduler_top_defines.svh"

// A request is taken when start is high and busy is low. A tick request visits
// one slot per cycle through a single increment-and-compare unit, so it keeps
// busy high through the scan of every slot and the flush state that follows
// it; configure and send-now requests keep busy high for one cycle, and
// ignored requests for none. Messages come out at most one per cycle on
// out_valid, in slot order, and cannot be held off by the receiver; out_last
// marks the final message of a request. Because a message is only known to
// be the last once the scan is done, each due slot is held until the next
// due slot is found or the scan ends, and the final message appears in the
// first cycle in which busy is low again.
module periodic_can_message_scheduler_top #(
    parameter int NUM_SLOTS = pcms_pkg::NUM_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  slot,
    input  logic        enable,
    input  logic [15:0] period,
    input  logic [31:0] msg_id,
    input  logic [7:0]  msg_length,
    input  logic [63:0] msg_payload,
    output logic        out_valid,
    output logic [31:0] out_id,
    output logic [3:0]  out_length,
    output logic [63:0] out_payload,
    output logic        out_last
);
    import pcms_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // Slot table.
    logic        en_reg   [NUM_SLOTS];
    logic [15:0] per_reg  [NUM_SLOTS];
    logic [15:0] cnt_reg  [NUM_SLOTS];
    logic [31:0] id_reg   [NUM_SLOTS];
    logic [3:0]  len_reg  [NUM_SLOTS];
    logic [63:0] data_reg [NUM_SLOTS];

    // Sequencer and latched request.
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] req_slot_reg;
    logic             req_en_reg;
    logic [15:0]      req_per_reg;
    msg_t             req_msg_reg;

    // Message waiting to learn whether it is the last one.
    msg_t pend_reg;
    logic pend_valid_reg;

    // Output registers.
    logic out_valid_reg;
    logic out_last_reg;
    msg_t out_msg_reg;

    logic             accept;
    logic             slot_ok;
    logic             len_ok;
    logic [IDX_W-1:0] addr;
    logic [15:0]      cnt_inc;
    logic             due;
    logic             scan_hit;
    logic             cfg_wr;
    logic [63:0]      cfg_mask;
    logic [63:0]      cfg_data;

    assign accept  = start && (state_reg == ST_IDLE);
    assign slot_ok = (slot < 8'(NUM_SLOTS));
    assign len_ok  = (msg_length <= MAX_DLC);

    // One table address serves both the configure write and the scan.
    assign addr = (state_reg == ST_CFG) ? req_slot_reg : idx_reg;

    // Shared increment-and-compare unit.
    assign cnt_inc = cnt_reg[addr] + 16'd1;
    assign due     = (cnt_inc >= per_reg[addr]);

    // Byte-masked payload merge for a configure request.
    assign cfg_mask = byte_mask(req_msg_reg.len);
    assign cfg_data = (data_reg[addr] & ~cfg_mask) | (req_msg_reg.data & cfg_mask);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    priority if (req_type == REQ_TICK)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req_type == REQ_CFG && slot_ok && len_ok)
                    begin
                        state_next = ST_CFG;
                    end
                    else if (req_type == REQ_SEND && len_ok)
                    begin
                        state_next = ST_SEND;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CFG:   state_next = ST_IDLE;
            ST_SCAN:  state_next = (idx_reg == LAST_IDX) ? ST_FLUSH : ST_SCAN;
            ST_FLUSH: state_next = ST_IDLE;
            ST_SEND:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        scan_hit = 1'b0;
        cfg_wr   = 1'b0;
        unique case (state_reg)
            ST_SCAN:  scan_hit = en_reg[addr] && due;
            ST_CFG:   cfg_wr   = 1'b1;
            default:
            begin
                scan_hit = 1'b0;
                cfg_wr   = 1'b0;
            end
        endcase
    end

    // State register and scan index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN && idx_reg != LAST_IDX)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // Latch the accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_slot_reg     <= slot[IDX_W-1:0];
            req_en_reg       <= enable;
            req_per_reg      <= period;
            req_msg_reg.id   <= msg_id;
            req_msg_reg.len  <= msg_length[3:0];
            req_msg_reg.data <= msg_payload;
        end
    end

    // Slot table updates: configure write and counter stepping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                en_reg[i]   <= 1'b0;
                per_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                id_reg[i]   <= '0;
                len_reg[i]  <= '0;
                data_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            en_reg[addr]   <= req_en_reg;
            per_reg[addr]  <= req_per_reg;
            cnt_reg[addr]  <= '0;
            id_reg[addr]   <= req_msg_reg.id;
            len_reg[addr]  <= req_msg_reg.len;
            data_reg[addr] <= cfg_data;
        end
        else if (state_reg == ST_SCAN && en_reg[addr])
        begin
            cnt_reg[addr] <= due ? 16'd0 : cnt_inc;
        end
    end

    // Pending message and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            if (scan_hit)
            begin
                // A newly due slot releases the one held before it.
                pend_valid_reg <= 1'b1;
                pend_reg.id    <= id_reg[addr];
                pend_reg.len   <= len_reg[addr];
                pend_reg.data  <= data_reg[addr];
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_msg_reg   <= pend_reg;
                end
            end
            else if (state_reg == ST_FLUSH)
            begin
                pend_valid_reg <= 1'b0;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= 1'b1;
                    out_msg_reg   <= pend_reg;
                end
            end
            else if (state_reg == ST_SEND)
            begin
                out_valid_reg    <= 1'b1;
                out_last_reg     <= 1'b1;
                out_msg_reg.id   <= req_msg_reg.id;
                out_msg_reg.len  <= req_msg_reg.len;
                out_msg_reg.data <= req_msg_reg.data & byte_mask(req_msg_reg.len);
            end
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_last    = out_last_reg;
    assign out_id      = out_msg_reg.id;
    assign out_length  = out_msg_reg.len;
    assign out_payload = out_msg_reg.data;

    // The cycle after an accepted request never carries a message.
    `PCMS_ASSERT_NEXT(a_no_out_after_accept, clk, rst_n, start && !busy, !out_valid,
        "message shown right after a request was accepted")

    // The last message of a request is never followed directly by another.
    `PCMS_ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_valid && out_last, !out_valid,
        "message shown right after the last message")

    // A message that is not the last one is only shown while the scan goes on.
    `PCMS_ASSERT_NOW(a_mid_in_scan, clk, rst_n, out_valid && !out_last,
        state_reg == ST_SCAN || state_reg == ST_FLUSH,
        "non-last message shown outside a tick scan")

    // Emitted lengths are always valid data length codes.
    `PCMS_ASSERT_NOW(a_len_range, clk, rst_n, out_valid, out_length <= 4'd8,
        "emitted length above eight")

endmodule
